// ===== hw/rtl/ahc_pkg.sv =====
`default_nettype none
package ahc_pkg;

   localparam int NUM_SYMBOLS_DEF   = 512;
   localparam int MAX_CODE_BITS_DEF = 32;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESCALE_LIMIT = 1'b1;

   localparam logic [15:0] COUNT_MAX     = 16'hffff;
   localparam logic [15:0] LIMIT_RESET   = 16'h8000;
   localparam logic [31:0] CODE_ALL_ONES = 32'hffffffff;

   typedef struct packed {
      logic [8:0] symbol;
      logic       code_bit;
   } req_type;

   typedef struct packed {
      logic [31:0] code_word;
      logic [5:0]  code_length;
      logic        code_too_long;
      logic [8:0]  decoded_symbol;
      logic        symbol_valid;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/adaptive_huffman_coder.sv =====
`default_nettype none
// adaptive huffman coder, lzhuf style. the tree is kept in sibling order in three
// single-port-write rams (node counts, child links, parent links) that one small
// sequencer walks with a single incrementer/comparator. after reset the block
// runs a build pass that lays down the balanced pairing tree; req_ready stays
// low meanwhile, csr writes are taken at any time. csr index 0 is decode_mode
// (0 encode, 1 decode), index 1 is rescale_limit. encode: one item is one
// symbol; the code is walked leaf to root, one code bit per level, then one item
// comes out. decode: one item is one code bit; every item gives one result,
// symbol_valid marks a completed symbol. each coded symbol then runs the count
// update: it climbs the tree level by level, searching node by node for the
// reorder partner and swapping where needed. when the root count has reached
// rescale_limit the update first halves all counts and rebuilds the tree, with
// a sorted insertion that moves entries one at a time. the next item is taken
// only when all this work is done; a finished result waits in the output
// register without blocking the update. symbols at or above NUM_SYMBOLS are
// dropped with no result.
module adaptive_huffman_coder #(
   parameter int NUM_SYMBOLS   = ahc_pkg::NUM_SYMBOLS_DEF,
   parameter int MAX_CODE_BITS = ahc_pkg::MAX_CODE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire ahc_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output ahc_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [ahc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ahc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import ahc_pkg::*;

   // tree geometry
   localparam int TN   = 2 * NUM_SYMBOLS - 1;       // node count, guard entry at TN
   localparam int RN   = TN - 1;                    // root
   localparam int NW   = $clog2(2 * NUM_SYMBOLS);   // node index
   localparam int CHW  = $clog2(3 * NUM_SYMBOLS);   // child link value
   localparam int PAW  = $clog2(TN + NUM_SYMBOLS);  // parent ram address
   localparam int SYMW = $clog2(NUM_SYMBOLS);
   localparam int CAP  = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;

   localparam logic [NW-1:0]  T_N   = NW'(TN);
   localparam logic [NW-1:0]  R_N   = NW'(RN);
   localparam logic [NW-1:0]  S_N   = NW'(NUM_SYMBOLS);
   localparam logic [NW:0]    T_W   = (NW+1)'(TN);
   localparam logic [CHW-1:0] T_C   = CHW'(TN);
   localparam logic [CHW-1:0] S_C   = CHW'(NUM_SYMBOLS);
   localparam logic [CHW-1:0] TS_C  = CHW'(TN + NUM_SYMBOLS);
   localparam logic [31:0]    CODE_MASK = ~(CODE_ALL_ONES >> CAP);

   // sequencer states
   localparam logic [5:0] ST_INIT_LEAF   = 6'd0;
   localparam logic [5:0] ST_INIT_RD0    = 6'd1;
   localparam logic [5:0] ST_INIT_RD1    = 6'd2;
   localparam logic [5:0] ST_INIT_WR0    = 6'd3;
   localparam logic [5:0] ST_INIT_WR1    = 6'd4;
   localparam logic [5:0] ST_INIT_TOP    = 6'd5;
   localparam logic [5:0] ST_IDLE        = 6'd6;
   localparam logic [5:0] ST_ENC_RD      = 6'd7;
   localparam logic [5:0] ST_ENC_LD      = 6'd8;
   localparam logic [5:0] ST_ENC_STEP    = 6'd9;
   localparam logic [5:0] ST_ENC_UP      = 6'd10;
   localparam logic [5:0] ST_DEC_ROOT    = 6'd11;
   localparam logic [5:0] ST_DEC_ROOT_LD = 6'd12;
   localparam logic [5:0] ST_DEC_RD      = 6'd13;
   localparam logic [5:0] ST_DEC_LD      = 6'd14;
   localparam logic [5:0] ST_OUT         = 6'd15;
   localparam logic [5:0] ST_BMP_RD      = 6'd16;
   localparam logic [5:0] ST_BMP_CHK     = 6'd17;
   localparam logic [5:0] ST_BMP_LEAF_RD = 6'd18;
   localparam logic [5:0] ST_BMP_LEAF_LD = 6'd19;
   localparam logic [5:0] ST_UPD_TOP     = 6'd20;
   localparam logic [5:0] ST_UPD_INC     = 6'd21;
   localparam logic [5:0] ST_UPD_CMP     = 6'd22;
   localparam logic [5:0] ST_SRCH_RD     = 6'd23;
   localparam logic [5:0] ST_SRCH_CMP    = 6'd24;
   localparam logic [5:0] ST_SWP_RD      = 6'd25;
   localparam logic [5:0] ST_SWP_1       = 6'd26;
   localparam logic [5:0] ST_SWP_2       = 6'd27;
   localparam logic [5:0] ST_SWP_3       = 6'd28;
   localparam logic [5:0] ST_SWP_4       = 6'd29;
   localparam logic [5:0] ST_SWP_5       = 6'd30;
   localparam logic [5:0] ST_SWP_6       = 6'd31;
   localparam logic [5:0] ST_UPD_NEXT    = 6'd32;
   localparam logic [5:0] ST_UPD_UP      = 6'd33;
   localparam logic [5:0] ST_RB_SCAN     = 6'd34;
   localparam logic [5:0] ST_RB_SCAN_CHK = 6'd35;
   localparam logic [5:0] ST_RB_COPY     = 6'd36;
   localparam logic [5:0] ST_RB_PAIR     = 6'd37;
   localparam logic [5:0] ST_RB_PAIR1    = 6'd38;
   localparam logic [5:0] ST_RB_PAIR2    = 6'd39;
   localparam logic [5:0] ST_RB_POS      = 6'd40;
   localparam logic [5:0] ST_RB_SHIFT    = 6'd41;
   localparam logic [5:0] ST_RB_INS      = 6'd42;
   localparam logic [5:0] ST_RB_LINK     = 6'd43;
   localparam logic [5:0] ST_RB_LINK_CHK = 6'd44;
   localparam logic [5:0] ST_RB_LINK2    = 6'd45;

   // control state
   logic [5:0]      state_ff, state_in;
   logic            mode_ff, mode_in;
   logic [15:0]     limit_ff, limit_in;
   logic            stale_ff, stale_in;     // decode walk must restart at the root
   logic            rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]   a_ff, a_in;             // init leaf, scan source, pair base, link index
   logic [NW-1:0]   dst_ff, dst_in;         // init node, rebuild destination

   // working registers
   logic [NW-1:0]   dn_ff, dn_in;           // decode walk position
   logic            bit_ff, bit_in;
   logic [SYMW-1:0] sym_ff, sym_in;
   logic            leaf_ff, leaf_in;
   logic [31:0]     acc_ff, acc_in;
   logic [NW-1:0]   len_ff, len_in;
   logic [NW-1:0]   guard_ff, guard_in;
   logic [NW-1:0]   c_ff, c_in;
   logic [NW-1:0]   l_ff, l_in;
   logic [NW:0]     p_ff, p_in;
   logic [NW-1:0]   pos_ff, pos_in;
   logic [15:0]     k_ff, k_in;             // bumped count, also pair sum in rebuild
   logic [CHW-1:0]  x_ff, x_in;
   logic [CHW-1:0]  y_ff, y_in;
   rsp_type         rsp_ff, rsp_in;

   // ram ports
   logic            cnt_we, chl_we, par_we;
   logic [NW-1:0]   cnt_waddr, cnt_raddr, chl_waddr, chl_raddr;
   logic [PAW-1:0]  par_waddr, par_raddr;
   logic [15:0]     cnt_wdata, cnt_rd;
   logic [CHW-1:0]  chl_wdata, chl_rd;
   logic [NW-1:0]   par_wdata, par_rd;

   // shared arithmetic
   logic [16:0]     inc_sum, pair_sum, half_sum;
   logic [15:0]     inc_sat, pair_sat;
   logic [NW:0]     dec_idx, l_pick;
   logic [NW-1:0]   dec_c, l_clamp;
   logic [CHW-1:0]  dec_sym, leaf_addr;
   logic [NW-1:0]   len_next;
   logic            req_take, out_free;

   ahc_ram #(.WIDTH(16), .DEPTH(2 * NUM_SYMBOLS)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rd)
   );

   ahc_ram #(.WIDTH(CHW), .DEPTH(TN)) u_chl_ram (
      .clock (clock),
      .we    (chl_we),
      .waddr (chl_waddr),
      .wdata (chl_wdata),
      .raddr (chl_raddr),
      .rdata (chl_rd)
   );

   ahc_ram #(.WIDTH(NW), .DEPTH(TN + NUM_SYMBOLS)) u_par_ram (
      .clock (clock),
      .we    (par_we),
      .waddr (par_waddr),
      .wdata (par_wdata),
      .raddr (par_raddr),
      .rdata (par_rd)
   );

   assign inc_sum  = {1'b0, cnt_rd} + 17'd1;
   assign inc_sat  = inc_sum[16] ? COUNT_MAX : inc_sum[15:0];
   assign pair_sum = {1'b0, k_ff} + {1'b0, cnt_rd};
   assign pair_sat = pair_sum[16] ? COUNT_MAX : pair_sum[15:0];
   assign half_sum = inc_sum;  // halved with rounding up: (n + 1) >> 1

   // decode step target, clamped to the last node
   assign dec_idx = {1'b0, dn_ff} + (NW+1)'(bit_ff);
   assign dec_c   = (dec_idx >= T_W) ? (T_N - NW'(1)) : dec_idx[NW-1:0];
   assign dec_sym = (chl_rd - T_C >= S_C) ? (S_C - CHW'(1)) : (chl_rd - T_C);

   // swap partner: last node whose count is still below the bumped count
   assign l_pick  = p_ff - (NW+1)'(1);
   assign l_clamp = (l_pick >= T_W) ? (T_N - NW'(1)) : l_pick[NW-1:0];

   assign leaf_addr = T_C + CHW'(sym_ff);
   assign len_next  = len_ff + NW'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      limit_in     = limit_ff;
      stale_in     = stale_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      a_in         = a_ff;
      dst_in       = dst_ff;
      dn_in        = dn_ff;
      bit_in       = bit_ff;
      sym_in       = sym_ff;
      leaf_in      = leaf_ff;
      acc_in       = acc_ff;
      len_in       = len_ff;
      guard_in     = guard_ff;
      c_in         = c_ff;
      l_in         = l_ff;
      p_in         = p_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      y_in         = y_ff;

      cnt_we    = 1'b0;
      cnt_waddr = '0;
      cnt_wdata = '0;
      cnt_raddr = '0;
      chl_we    = 1'b0;
      chl_waddr = '0;
      chl_wdata = '0;
      chl_raddr = '0;
      par_we    = 1'b0;
      par_waddr = '0;
      par_wdata = '0;
      par_raddr = '0;

      case (state_ff)
         // build pass after reset: leaves first
         ST_INIT_LEAF: begin
            cnt_we    = 1'b1;
            cnt_waddr = a_ff;
            cnt_wdata = 16'd1;
            chl_we    = 1'b1;
            chl_waddr = a_ff;
            chl_wdata = CHW'(a_ff) + T_C;
            par_we    = 1'b1;
            par_waddr = PAW'(CHW'(a_ff) + T_C);
            par_wdata = a_ff;
            if (a_ff == S_N - NW'(1)) begin
               a_in     = '0;
               dst_in   = S_N;
               state_in = ST_INIT_RD0;
            end else begin
               a_in = a_ff + NW'(1);
            end
         end
         // internal nodes join pairs in order
         ST_INIT_RD0: begin
            cnt_raddr = a_ff;
            state_in  = ST_INIT_RD1;
         end
         ST_INIT_RD1: begin
            k_in      = cnt_rd;
            cnt_raddr = a_ff + NW'(1);
            state_in  = ST_INIT_WR0;
         end
         ST_INIT_WR0: begin
            cnt_we    = 1'b1;
            cnt_waddr = dst_ff;
            cnt_wdata = pair_sat;
            chl_we    = 1'b1;
            chl_waddr = dst_ff;
            chl_wdata = CHW'(a_ff);
            par_we    = 1'b1;
            par_waddr = PAW'(a_ff);
            par_wdata = dst_ff;
            state_in  = ST_INIT_WR1;
         end
         ST_INIT_WR1: begin
            par_we    = 1'b1;
            par_waddr = PAW'(a_ff + NW'(1));
            par_wdata = dst_ff;
            if (dst_ff == R_N) begin
               state_in = ST_INIT_TOP;
            end else begin
               dst_in   = dst_ff + NW'(1);
               a_in     = a_ff + NW'(2);
               state_in = ST_INIT_RD0;
            end
         end
         // guard count above the root, root has no parent
         ST_INIT_TOP: begin
            cnt_we    = 1'b1;
            cnt_waddr = T_N;
            cnt_wdata = COUNT_MAX;
            par_we    = 1'b1;
            par_waddr = PAW'(R_N);
            par_wdata = '0;
            state_in  = ST_IDLE;
         end

         ST_IDLE: begin
            if (req_take) begin
               if (!mode_ff) begin
                  if ({2'b00, req_data.symbol} < 11'(NUM_SYMBOLS)) begin
                     sym_in   = SYMW'(req_data.symbol);
                     acc_in   = '0;
                     len_in   = '0;
                     state_in = ST_ENC_RD;
                  end
               end else begin
                  bit_in   = req_data.code_bit;
                  state_in = stale_ff ? ST_DEC_ROOT : ST_DEC_RD;
               end
            end
         end

         // encode: climb from the leaf, one code bit per level
         ST_ENC_RD: begin
            par_raddr = PAW'(leaf_addr);
            state_in  = ST_ENC_LD;
         end
         ST_ENC_LD: begin
            c_in     = par_rd;
            state_in = ST_ENC_STEP;
         end
         ST_ENC_STEP: begin
            acc_in    = {c_ff[0], acc_ff[31:1]};
            len_in    = len_next;
            par_raddr = PAW'(c_ff);
            if (c_ff >= T_N || len_next == T_N) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_ENC_UP;
            end
         end
         ST_ENC_UP: begin
            c_in     = par_rd;
            state_in = (par_rd == R_N) ? ST_OUT : ST_ENC_STEP;
         end

         // decode: restart at the root if needed, then step one bit
         ST_DEC_ROOT: begin
            chl_raddr = R_N;
            state_in  = ST_DEC_ROOT_LD;
         end
         ST_DEC_ROOT_LD: begin
            dn_in    = NW'(chl_rd);
            stale_in = 1'b0;
            state_in = ST_DEC_RD;
         end
         ST_DEC_RD: begin
            chl_raddr = dec_c;
            state_in  = ST_DEC_LD;
         end
         ST_DEC_LD: begin
            if (chl_rd >= T_C) begin
               sym_in  = SYMW'(dec_sym);
               leaf_in = 1'b1;
            end else begin
               dn_in   = NW'(chl_rd);
               leaf_in = 1'b0;
            end
            state_in = ST_OUT;
         end

         // result into the output register, then the count update if a symbol was coded
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (!mode_ff) begin
                  if (int'(len_ff) > CAP) begin
                     rsp_in.code_word     = acc_ff & CODE_MASK;
                     rsp_in.code_length   = 6'(CAP);
                     rsp_in.code_too_long = 1'b1;
                  end else begin
                     rsp_in.code_word   = acc_ff;
                     rsp_in.code_length = 6'(len_ff);
                  end
               end else if (leaf_ff) begin
                  rsp_in.decoded_symbol = 9'(sym_ff);
                  rsp_in.symbol_valid   = 1'b1;
               end
               if (!mode_ff || leaf_ff) begin
                  stale_in = 1'b1;
                  state_in = ST_BMP_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // count update
         ST_BMP_RD: begin
            cnt_raddr = R_N;
            state_in  = ST_BMP_CHK;
         end
         ST_BMP_CHK: begin
            if (cnt_rd >= limit_ff) begin
               a_in     = '0;
               dst_in   = '0;
               state_in = ST_RB_SCAN;
            end else begin
               state_in = ST_BMP_LEAF_RD;
            end
         end
         ST_BMP_LEAF_RD: begin
            par_raddr = PAW'(leaf_addr);
            state_in  = ST_BMP_LEAF_LD;
         end
         ST_BMP_LEAF_LD: begin
            c_in     = par_rd;
            guard_in = '0;
            state_in = ST_UPD_TOP;
         end
         ST_UPD_TOP: begin
            cnt_raddr = c_ff;
            if (c_ff >= T_N || guard_ff == T_N) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_UPD_INC;
            end
         end
         ST_UPD_INC: begin
            k_in      = inc_sat;
            cnt_we    = 1'b1;
            cnt_waddr = c_ff;
            cnt_wdata = inc_sat;
            cnt_raddr = c_ff + NW'(1);
            state_in  = ST_UPD_CMP;
         end
         ST_UPD_CMP: begin
            if (k_ff > cnt_rd) begin
               p_in     = {1'b0, c_ff} + (NW+1)'(2);
               state_in = ST_SRCH_RD;
            end else begin
               state_in = ST_UPD_NEXT;
            end
         end
         // forward search for the last node with a smaller count
         ST_SRCH_RD: begin
            cnt_raddr = p_ff[NW-1:0];
            if (p_ff > T_W) begin
               l_in     = l_clamp;
               state_in = ST_SWP_RD;
            end else begin
               state_in = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            if (k_ff > cnt_rd) begin
               p_in     = p_ff + (NW+1)'(1);
               state_in = ST_SRCH_RD;
            end else begin
               l_in     = l_clamp;
               state_in = ST_SWP_RD;
            end
         end
         // swap nodes c and l, relinking both subtrees
         ST_SWP_RD: begin
            cnt_raddr = l_ff;
            state_in  = ST_SWP_1;
         end
         ST_SWP_1: begin
            cnt_we    = 1'b1;
            cnt_waddr = c_ff;
            cnt_wdata = cnt_rd;
            chl_raddr = c_ff;
            state_in  = ST_SWP_2;
         end
         ST_SWP_2: begin
            x_in      = chl_rd;
            cnt_we    = 1'b1;
            cnt_waddr = l_ff;
            cnt_wdata = k_ff;
            chl_raddr = l_ff;
            state_in  = ST_SWP_3;
         end
         ST_SWP_3: begin
            y_in      = chl_rd;
            par_we    = (x_ff < TS_C);
            par_waddr = PAW'(x_ff);
            par_wdata = l_ff;
            chl_we    = 1'b1;
            chl_waddr = l_ff;
            chl_wdata = x_ff;
            state_in  = ST_SWP_4;
         end
         ST_SWP_4: begin
            par_we    = (x_ff < T_C);
            par_waddr = PAW'(x_ff + CHW'(1));
            par_wdata = l_ff;
            chl_we    = 1'b1;
            chl_waddr = c_ff;
            chl_wdata = y_ff;
            state_in  = ST_SWP_5;
         end
         ST_SWP_5: begin
            par_we    = (y_ff < TS_C);
            par_waddr = PAW'(y_ff);
            par_wdata = c_ff;
            state_in  = ST_SWP_6;
         end
         ST_SWP_6: begin
            par_we    = (y_ff < T_C);
            par_waddr = PAW'(y_ff + CHW'(1));
            par_wdata = c_ff;
            c_in      = l_ff;
            state_in  = ST_UPD_NEXT;
         end
         ST_UPD_NEXT: begin
            par_raddr = PAW'(c_ff);
            state_in  = (c_ff == R_N) ? ST_IDLE : ST_UPD_UP;
         end
         ST_UPD_UP: begin
            c_in     = par_rd;
            guard_in = guard_ff + NW'(1);
            state_in = ST_UPD_TOP;
         end

         // rebuild: gather leaves with halved counts
         ST_RB_SCAN: begin
            chl_raddr = a_ff;
            if (a_ff == T_N) begin
               a_in     = '0;
               dst_in   = S_N;
               state_in = ST_RB_PAIR;
            end else begin
               state_in = ST_RB_SCAN_CHK;
            end
         end
         ST_RB_SCAN_CHK: begin
            x_in      = chl_rd;
            cnt_raddr = a_ff;
            if (chl_rd >= T_C && dst_ff < S_N) begin
               state_in = ST_RB_COPY;
            end else begin
               a_in     = a_ff + NW'(1);
               state_in = ST_RB_SCAN;
            end
         end
         ST_RB_COPY: begin
            cnt_we    = 1'b1;
            cnt_waddr = dst_ff;
            cnt_wdata = half_sum[16:1];
            chl_we    = 1'b1;
            chl_waddr = dst_ff;
            chl_wdata = x_ff;
            dst_in    = dst_ff + NW'(1);
            a_in      = a_ff + NW'(1);
            state_in  = ST_RB_SCAN;
         end
         // join pairs and insert each sum in sorted place
         ST_RB_PAIR: begin
            cnt_raddr = a_ff;
            if (dst_ff == T_N) begin
               a_in     = '0;
               state_in = ST_RB_LINK;
            end else begin
               state_in = ST_RB_PAIR1;
            end
         end
         ST_RB_PAIR1: begin
            k_in      = cnt_rd;
            cnt_raddr = a_ff + NW'(1);
            state_in  = ST_RB_PAIR2;
         end
         ST_RB_PAIR2: begin
            k_in     = pair_sat;
            pos_in   = dst_ff;
            state_in = ST_RB_POS;
         end
         ST_RB_POS: begin
            cnt_raddr = pos_ff - NW'(1);
            chl_raddr = pos_ff - NW'(1);
            state_in  = (pos_ff == '0) ? ST_RB_INS : ST_RB_SHIFT;
         end
         ST_RB_SHIFT: begin
            if (k_ff < cnt_rd) begin
               cnt_we    = 1'b1;
               cnt_waddr = pos_ff;
               cnt_wdata = cnt_rd;
               chl_we    = 1'b1;
               chl_waddr = pos_ff;
               chl_wdata = chl_rd;
               pos_in    = pos_ff - NW'(1);
               state_in  = ST_RB_POS;
            end else begin
               state_in = ST_RB_INS;
            end
         end
         ST_RB_INS: begin
            cnt_we    = 1'b1;
            cnt_waddr = pos_ff;
            cnt_wdata = k_ff;
            chl_we    = 1'b1;
            chl_waddr = pos_ff;
            chl_wdata = CHW'(a_ff);
            a_in      = a_ff + NW'(2);
            dst_in    = dst_ff + NW'(1);
            state_in  = ST_RB_PAIR;
         end
         // relink parents from the new child links
         ST_RB_LINK: begin
            chl_raddr = a_ff;
            state_in  = (a_ff == T_N) ? ST_BMP_LEAF_RD : ST_RB_LINK_CHK;
         end
         ST_RB_LINK_CHK: begin
            x_in      = chl_rd;
            par_waddr = PAW'(chl_rd);
            par_wdata = a_ff;
            if (chl_rd >= T_C) begin
               par_we   = (chl_rd < TS_C);
               a_in     = a_ff + NW'(1);
               state_in = ST_RB_LINK;
            end else begin
               par_we   = 1'b1;
               state_in = ST_RB_LINK2;
            end
         end
         ST_RB_LINK2: begin
            par_we    = 1'b1;
            par_waddr = PAW'(x_ff + CHW'(1));
            par_wdata = a_ff;
            a_in      = a_ff + NW'(1);
            state_in  = ST_RB_LINK;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes, taken in any state
      if (csr_we) begin
         if (csr_index == CSR_DECODE_MODE) begin
            mode_in  = csr_wdata[0];
            stale_in = 1'b1;
         end else if (csr_index == CSR_RESCALE_LIMIT) begin
            limit_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_LEAF;
         mode_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         a_ff         <= '0;
         dst_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         limit_ff     <= limit_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
         a_ff         <= a_in;
         dst_ff       <= dst_in;
      end
      dn_ff    <= dn_in;
      bit_ff   <= bit_in;
      sym_ff   <= sym_in;
      leaf_ff  <= leaf_in;
      acc_ff   <= acc_in;
      len_ff   <= len_in;
      guard_ff <= guard_in;
      c_ff     <= c_in;
      l_ff     <= l_in;
      p_ff     <= p_in;
      pos_ff   <= pos_in;
      k_ff     <= k_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      rsp_ff   <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ahc_ram.sv =====
`default_nettype none
module ahc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire
